// ===== rtl/assert_macros.svh =====
// Assertion macros used by the gesture unit RTL.
// Expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tgm_pkg.sv =====
// Types and constants for the touch gesture to mouse unit.
// No dependencies.
package tgm_pkg;

  localparam int unsigned ACC_W    = 40;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned HOLD_MS  = 450;
  localparam int unsigned DTAP_MS  = 400;
  localparam int unsigned CLICK_MS = 70;

  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_MOTION = 2'd1;
  localparam logic [1:0] KIND_UP     = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_MOVE   = 2'd2;

  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_LEFT  = 2'd1;
  localparam logic [1:0] HELD_RIGHT = 2'd2;

  localparam logic BTN_LEFT  = 1'b0;
  localparam logic BTN_RIGHT = 1'b1;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAIN      = 2'd1;
  localparam logic [1:0] REG_QUANTUM   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_MULQ, S_DECIDE, S_SEND
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               button;
    logic               pressed;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } res_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic div_start;
    logic div_step;
    logic mulq_en;
    logic commit;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic div_done;
    logic res_last;
  } sts_t;

endpackage

// ===== rtl/tgm_ctrl.sv =====
// Sequencer for the gesture unit: steps one item through multiply, divide
// (ticks only), decide and send. Depends on tgm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tgm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output tgm_pkg::cmd_t cmd,
  input  tgm_pkg::sts_t sts
);
  import tgm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (sts.is_tick) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MULQ;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MULQ: begin
        cmd.mulq_en = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        state_nxt  = S_SEND;
      end
      S_SEND: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.res_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pop = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `ASSERT_IMPLY(a_no_overlap, in_tready, !out_tvalid, "input taken while sending")
  `ASSERT_NEXT(a_div_exit, (state_r == S_DIV) && sts.div_done, state_r == S_MULQ,
    "divider done but not left")
  `ASSERT_NEXT(a_commit_send, cmd.commit, out_tvalid, "commit not followed by send")

endmodule

// ===== rtl/tgm_dp.sv =====
// Datapath for the gesture unit: gesture state, multipliers, quantum divider
// and the result queue. Depends on tgm_pkg.
module tgm_dp #(
  parameter int TW  = 32,
  parameter int IDW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [95:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  tgm_pkg::cmd_t cmd,
  output tgm_pkg::sts_t sts,
  output logic [39:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);
  import tgm_pkg::*;

  logic [15:0] thr_r, gain_r;
  logic [7:0]  quant_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 16'd208;
      gain_r  <= 16'd256;
      quant_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r   <= cfg_data;
        REG_GAIN:      gain_r  <= cfg_data;
        REG_QUANTUM:   quant_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] q_eff;
  assign q_eff = (quant_r == 8'd0) ? 8'd1 : quant_r;

  // captured beat
  logic [1:0]     kind_r;
  logic [IDW-1:0] id_r;
  logic [15:0]    px_r, py_r;
  logic [TW-1:0]  now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_tuser;
      id_r   <= IDW'(in_tdata[31:0]);
      px_r   <= in_tdata[47:32];
      py_r   <= in_tdata[63:48];
      now_r  <= TW'(in_tdata[95:64]);
    end
  end

  // gesture state
  logic             tracking_r, tracking_nxt, moved_r, moved_nxt;
  logic             hold_r, hold_nxt, drag_r, drag_nxt, tapv_r, tapv_nxt;
  logic [IDW-1:0]   fid_r, fid_nxt;
  logic [15:0]      sx_r, sx_nxt, sy_r, sy_nxt, prx_r, prx_nxt, pry_r, pry_nxt;
  logic [15:0]      tx_r, tx_nxt, ty_r, ty_nxt;
  logic [TW-1:0]    tdown_r, tdown_nxt, trel_r, trel_nxt, ttap_r, ttap_nxt;
  logic [1:0]       held_r, held_nxt;
  logic signed [ACC_W-1:0] accx_r, accx_nxt, accy_r, accy_nxt;

  // products
  logic [31:0]        sqx_r, sqy_r, thr2_r;
  logic signed [33:0] prodx_r, prody_r;
  logic [15:0]        ax, ay;
  logic signed [16:0] ddx, ddy, mvx, mvy;
  logic signed [33:0] sqx_w, sqy_w;

  always_comb begin
    ax  = (kind_r == KIND_DOWN) ? tx_r : sx_r;
    ay  = (kind_r == KIND_DOWN) ? ty_r : sy_r;
    ddx = $signed({1'b0, px_r}) - $signed({1'b0, ax});
    ddy = $signed({1'b0, py_r}) - $signed({1'b0, ay});
    mvx = $signed({1'b0, px_r}) - $signed({1'b0, prx_r});
    mvy = $signed({1'b0, py_r}) - $signed({1'b0, pry_r});
    sqx_w = ddx * ddx;
    sqy_w = ddy * ddy;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      sqx_r   <= sqx_w[31:0];
      sqy_r   <= sqy_w[31:0];
      thr2_r  <= thr_r * thr_r;
      prodx_r <= mvx * $signed({1'b0, gain_r});
      prody_r <= mvy * $signed({1'b0, gain_r});
    end
  end

  // quantum divider, restoring, one bit per cycle on both axes
  logic [DIV_W-1:0]       qx_r, qy_r;
  logic [7:0]             rx_r, ry_r, lx_r, ly_r;
  logic                   nx_r, ny_r;
  logic [$clog2(DIV_W+1)-1:0] dcnt_r;
  logic [ACC_W-1:0]       magx, magy;
  logic [8:0]             trx, try_w;
  logic                   gex, gey;

  always_comb begin
    magx  = accx_r[ACC_W-1] ? ACC_W'(-accx_r) : ACC_W'(accx_r);
    magy  = accy_r[ACC_W-1] ? ACC_W'(-accy_r) : ACC_W'(accy_r);
    trx   = {rx_r, qx_r[DIV_W-1]};
    try_w = {ry_r, qy_r[DIV_W-1]};
    gex   = trx >= {1'b0, q_eff};
    gey   = try_w >= {1'b0, q_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= ($clog2(DIV_W+1))'(DIV_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      qx_r <= magx[ACC_W-1:8];
      qy_r <= magy[ACC_W-1:8];
      rx_r <= '0;
      ry_r <= '0;
      lx_r <= magx[7:0];
      ly_r <= magy[7:0];
      nx_r <= accx_r[ACC_W-1];
      ny_r <= accy_r[ACC_W-1];
    end else if (cmd.div_step) begin
      qx_r <= {qx_r[DIV_W-2:0], gex};
      qy_r <= {qy_r[DIV_W-2:0], gey};
      rx_r <= gex ? 8'(trx - {1'b0, q_eff}) : trx[7:0];
      ry_r <= gey ? 8'(try_w - {1'b0, q_eff}) : try_w[7:0];
    end
  end

  logic [39:0]        ux, uy;
  logic signed [15:0] mdx_r, mdy_r;

  always_comb begin
    ux = qx_r * q_eff;
    uy = qy_r * q_eff;
  end

  always_ff @(posedge clk) begin
    if (cmd.mulq_en) begin
      if (nx_r) mdx_r <= (ux > 40'd32768) ? 16'sh8000 : 16'(-ux);
      else      mdx_r <= (ux > 40'd32767) ? 16'sh7fff : ux[15:0];
      if (ny_r) mdy_r <= (uy > 40'd32768) ? 16'sh8000 : 16'(-uy);
      else      mdy_r <= (uy > 40'd32767) ? 16'sh7fff : uy[15:0];
    end
  end

  // accumulator add with truncation toward zero and saturation
  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [33:0]      p
  );
    logic signed [33:0]      s;
    logic signed [ACC_W:0]   r;
    s = p[33] ? -((-p) >>> 4) : (p >>> 4);
    r = $signed({acc[ACC_W-1], acc}) + (ACC_W+1)'(s);
    if (r[ACC_W] != r[ACC_W-1]) acc_add = r[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                    : {1'b0, {(ACC_W-1){1'b1}}};
    else acc_add = r[ACC_W-1:0];
  endfunction

  function automatic res_t mk(input logic [1:0] act, input logic btn,
                              input logic prs, input logic signed [15:0] dx,
                              input logic signed [15:0] dy);
    res_t r;
    r.action   = act;
    r.button   = btn;
    r.pressed  = prs;
    r.dx       = dx;
    r.dy       = dy;
    mk = r;
  endfunction

  // decision
  res_t       res_r [MAX_RES];
  res_t       res_nxt [MAX_RES];
  logic [1:0] cnt_r, cnt_nxt, idx_r;
  logic       cons_r, cons_nxt;
  logic [32:0] d2;
  logic        near, match;
  logic [TW-1:0] dt_tap, dt_down, dt_rel;
  logic [15:0]   mgx, mgy;

  always_comb begin
    tracking_nxt = tracking_r; moved_nxt = moved_r; hold_nxt = hold_r;
    drag_nxt = drag_r; tapv_nxt = tapv_r; fid_nxt = fid_r;
    sx_nxt = sx_r; sy_nxt = sy_r; prx_nxt = prx_r; pry_nxt = pry_r;
    tx_nxt = tx_r; ty_nxt = ty_r; tdown_nxt = tdown_r; trel_nxt = trel_r;
    ttap_nxt = ttap_r; held_nxt = held_r; accx_nxt = accx_r; accy_nxt = accy_r;
    for (int i = 0; i < MAX_RES; i++) res_nxt[i] = '0;
    cnt_nxt  = '0;
    cons_nxt = 1'b0;
    d2     = {1'b0, sqx_r} + {1'b0, sqy_r};
    near   = ({2'b0, d2, 2'b0} <= ({5'b0, thr2_r} << 4) + ({5'b0, thr2_r} << 3)
                                  + {5'b0, thr2_r});
    match  = tracking_r && (id_r == fid_r);
    dt_tap = now_r - ttap_r;
    dt_down = now_r - tdown_r;
    mgx = {rx_r, lx_r};
    mgy = {ry_r, ly_r};
    dt_rel = '0;
    case (kind_r)
      KIND_DOWN: begin
        cons_nxt = 1'b1;
        if (!tracking_r) begin
          tracking_nxt = 1'b1; fid_nxt = id_r;
          sx_nxt = px_r; prx_nxt = px_r; sy_nxt = py_r; pry_nxt = py_r;
          tdown_nxt = now_r; moved_nxt = 1'b0; hold_nxt = 1'b0;
          if (tapv_r && (dt_tap <= TW'(DTAP_MS)) && near) begin
            if (held_r == HELD_LEFT || held_r == HELD_RIGHT) begin
              res_nxt[cnt_nxt] = mk(ACT_BUTTON, held_r[1], 1'b0, '0, '0);
              cnt_nxt = cnt_nxt + 1'b1;
            end
            held_nxt = HELD_NONE;
            res_nxt[cnt_nxt] = mk(ACT_BUTTON, BTN_LEFT, 1'b1, '0, '0);
            cnt_nxt = cnt_nxt + 1'b1;
            drag_nxt = 1'b1;
          end
        end
      end
      KIND_MOTION: begin
        if (match) begin
          cons_nxt = 1'b1;
          accx_nxt = acc_add(accx_r, prodx_r);
          accy_nxt = acc_add(accy_r, prody_r);
          prx_nxt = px_r; pry_nxt = py_r;
          if (!moved_r && (d2 > {1'b0, thr2_r})) moved_nxt = 1'b1;
        end
      end
      KIND_UP: begin
        if (match) begin
          cons_nxt = 1'b1;
          tracking_nxt = 1'b0;
          if (drag_r) begin
            res_nxt[cnt_nxt] = mk(ACT_BUTTON, BTN_LEFT, 1'b0, '0, '0);
            cnt_nxt = cnt_nxt + 1'b1;
            drag_nxt = 1'b0;
          end else if (!moved_r && !hold_r) begin
            if (held_r == HELD_LEFT || held_r == HELD_RIGHT) begin
              res_nxt[cnt_nxt] = mk(ACT_BUTTON, held_r[1], 1'b0, '0, '0);
              cnt_nxt = cnt_nxt + 1'b1;
            end
            res_nxt[cnt_nxt] = mk(ACT_BUTTON, BTN_LEFT, 1'b1, '0, '0);
            cnt_nxt = cnt_nxt + 1'b1;
            held_nxt = HELD_LEFT;
            trel_nxt = now_r + TW'(CLICK_MS);
            tapv_nxt = 1'b1; ttap_nxt = now_r; tx_nxt = px_r; ty_nxt = py_r;
          end
        end
      end
      default: begin
        if (qx_r != '0 || qy_r != '0) begin
          res_nxt[cnt_nxt] = mk(ACT_MOVE, 1'b0, 1'b0, mdx_r, mdy_r);
          cnt_nxt = cnt_nxt + 1'b1;
        end
        accx_nxt = nx_r ? -$signed({24'b0, mgx}) : $signed({24'b0, mgx});
        accy_nxt = ny_r ? -$signed({24'b0, mgy}) : $signed({24'b0, mgy});
        if (tracking_r && !moved_r && !drag_r && !hold_r &&
            (dt_down >= TW'(HOLD_MS))) begin
          if (held_r == HELD_LEFT || held_r == HELD_RIGHT) begin
            res_nxt[cnt_nxt] = mk(ACT_BUTTON, held_r[1], 1'b0, '0, '0);
            cnt_nxt = cnt_nxt + 1'b1;
          end
          res_nxt[cnt_nxt] = mk(ACT_BUTTON, BTN_RIGHT, 1'b1, '0, '0);
          cnt_nxt = cnt_nxt + 1'b1;
          held_nxt = HELD_RIGHT;
          trel_nxt = now_r + TW'(CLICK_MS);
          hold_nxt = 1'b1;
        end
        dt_rel = now_r - trel_nxt;
        if ((held_nxt == HELD_LEFT || held_nxt == HELD_RIGHT) && !dt_rel[TW-1]) begin
          res_nxt[cnt_nxt] = mk(ACT_BUTTON, held_nxt[1], 1'b0, '0, '0);
          cnt_nxt = cnt_nxt + 1'b1;
          held_nxt = HELD_NONE;
        end
      end
    endcase
    if (cnt_nxt == 2'd0) begin
      res_nxt[0] = mk(ACT_NONE, 1'b0, 1'b0, '0, '0);
      cnt_nxt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r <= 1'b0; moved_r <= 1'b0; hold_r <= 1'b0; drag_r <= 1'b0;
      tapv_r <= 1'b0; fid_r <= '0; sx_r <= '0; sy_r <= '0; prx_r <= '0;
      pry_r <= '0; tx_r <= '0; ty_r <= '0; tdown_r <= '0; trel_r <= '0;
      ttap_r <= '0; held_r <= HELD_NONE; accx_r <= '0; accy_r <= '0;
      cnt_r <= 2'd1; idx_r <= '0;
    end else if (cmd.commit) begin
      tracking_r <= tracking_nxt; moved_r <= moved_nxt; hold_r <= hold_nxt;
      drag_r <= drag_nxt; tapv_r <= tapv_nxt; fid_r <= fid_nxt;
      sx_r <= sx_nxt; sy_r <= sy_nxt; prx_r <= prx_nxt; pry_r <= pry_nxt;
      tx_r <= tx_nxt; ty_r <= ty_nxt; tdown_r <= tdown_nxt; trel_r <= trel_nxt;
      ttap_r <= ttap_nxt; held_r <= held_nxt; accx_r <= accx_nxt;
      accy_r <= accy_nxt; cnt_r <= cnt_nxt; idx_r <= '0;
    end else if (cmd.pop) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r  <= res_nxt;
      cons_r <= cons_nxt;
    end
  end

  res_t cur;
  always_comb begin
    cur = res_r[idx_r];
    out_tuser = cur.action;
    out_tlast = (idx_r == cnt_r - 1'b1);
    out_tdata = {5'b0, cons_r, cur.dy, cur.dx, cur.pressed, cur.button};
    sts.is_tick  = (kind_r == KIND_TICK);
    sts.div_done = (dcnt_r == '0);
    sts.res_last = out_tlast;
  end

endmodule

// ===== rtl/touch_gesture_to_mouse_unit.sv =====
// Top level of the touch gesture to mouse unit.
// Instantiates tgm_ctrl and tgm_dp; depends on tgm_pkg.
//
// One beat in, one to three beats out. Touch down, motion and up pass the
// multiply and decide states before the first result; a tick also passes
// the 32-step restoring divider that splits the accumulated motion into
// whole quanta. Each result is held until out_tready is high, and a new
// input is taken only once the last result of the previous one has gone.
// Register writes are taken at any time and are registered.
module touch_gesture_to_mouse_unit #(
  parameter int TIME_WIDTH = 32,
  parameter int ID_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // finger_id, pos_x, pos_y, time_ms
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // button, pressed, move_dx, move_dy, consumed
  output logic [1:0]  out_tuser,  // action
  output logic        out_tlast
);
  import tgm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tgm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  tgm_dp #(
    .TW  (TIME_WIDTH),
    .IDW (ID_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
